// ===== src/iovl_pkg.sv =====
// shared types and constants of the interval overlap accumulator
`default_nettype none
package iovl_pkg;

  localparam int unsigned MAX_INTERVALS = 1024;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned ADDR_W        = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned ENTRY_W       = 2 * DATA_W;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              carry;
  } alu_res_t;

endpackage
`default_nettype wire

// ===== src/interval_overlap_accumulator.sv =====
// top level: interval table, walk cursor and query sequencer
`default_nettype none
// Interval overlap accumulator. Holds up to MAX_INTERVALS intervals [start, end)
// in a ram, and a walk cursor into them. Intervals must be appended in ascending
// start order; the block itself does not enforce it. func 0 clears the table
// and cursor, func 1 appends an interval (status 2 when the table is full),
// func 2 queries the span [span_start, span_end): starting at the cursor
// (or entry 0 when restart_cursor is set) it skips entries ending at or before
// the span start, stops at the first entry starting at or after the span end,
// and adds up the overlap of the entries between; an overlap that would carry
// past 2^64-1 is left out and reports status 1. The cursor steps past an
// overlapping entry only when the span reaches beyond its end. Every item gives
// exactly one result. One item is taken at a time and input stall stays high
// until its result is loaded into the output register. Each entry is worked
// through state by state, since the ram's read is registered and the single
// 64-bit add/subtract unit performs every bound compare, the overlap subtraction
// and the accumulation in turn. No clearing pass is needed after reset.
module interval_overlap_accumulator import iovl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        func_i,
  input  wire logic [DATA_W-1:0] span_start_i,
  input  wire logic [DATA_W-1:0] span_end_i,
  input  wire logic              restart_cursor_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [DATA_W-1:0]      overlap_total_o,
  output logic [1:0]             status_o
);

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_FETCH = 9'b0_0000_0010,  // issue ram read at cursor, or finish
    S_SKIP  = 9'b0_0000_0100,  // query start >= entry end
    S_STOP  = 9'b0_0000_1000,  // entry start >= query end
    S_LO    = 9'b0_0001_0000,  // lower bound of the overlap
    S_HI    = 9'b0_0010_0000,  // upper bound and cursor step
    S_PART  = 9'b0_0100_0000,  // overlap length
    S_ADD   = 9'b0_1000_0000,  // accumulate with carry check
    S_DONE  = 9'b1_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic [DATA_W-1:0] qs_q, qs_d, qe_q, qe_d;
  logic [DATA_W-1:0] lo_q, lo_d, hi_q, hi_d, part_q, part_d;
  logic [DATA_W-1:0] total_q, total_d;
  logic [1:0]        stat_q, stat_d;
  logic              adv_q, adv_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_total_q;
  logic [1:0]        out_stat_q;

  logic              in_acc;
  logic              out_load;
  logic              ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [DATA_W-1:0] es, ee;
  alu_req_t          alu_req;
  alu_res_t          alu_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // entry layout: start in the upper half, end in the lower half
  assign es = ram_rdata[ENTRY_W-1:DATA_W];
  assign ee = ram_rdata[DATA_W-1:0];

  // append writes at accept time when there is room
  assign ram_we = in_acc && (func_i == FUNC_APPEND) && (count_q < CNT_W'(MAX_INTERVALS));
  assign ram_re = (state_q == S_FETCH) && (cursor_q < count_q);

  iovl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_INTERVALS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({span_start_i, span_end_i}),
    .re_i    (ram_re),
    .raddr_i (cursor_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // operand select for the shared unit
  always_comb begin
    alu_req.a   = total_q;
    alu_req.b   = part_q;
    alu_req.sub = 1'b1;
    case (state_q)
      S_SKIP: begin
        alu_req.a = qs_q;
        alu_req.b = ee;
      end
      S_STOP: begin
        alu_req.a = es;
        alu_req.b = qe_q;
      end
      S_LO: begin
        alu_req.a = es;
        alu_req.b = qs_q;
      end
      S_HI: begin
        alu_req.a = ee;
        alu_req.b = qe_q;
      end
      S_PART: begin
        alu_req.a = hi_q;
        alu_req.b = lo_q;
      end
      S_ADD: begin
        alu_req.sub = 1'b0;
      end
      default: begin
        alu_req.sub = 1'b1;
      end
    endcase
  end

  iovl_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // output register frees when empty or being taken
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    qs_d     = qs_q;
    qe_d     = qe_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    part_d   = part_q;
    total_d  = total_q;
    stat_d   = stat_q;
    adv_d    = adv_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          qs_d    = span_start_i;
          qe_d    = span_end_i;
          total_d = '0;
          stat_d  = STAT_OK;
          state_d = S_DONE;
          case (func_i)
            FUNC_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
            end
            FUNC_APPEND: begin
              if (count_q < CNT_W'(MAX_INTERVALS)) begin
                count_d = count_q + CNT_W'(1);
              end else begin
                stat_d = STAT_FULL;
              end
            end
            FUNC_QUERY: begin
              if (restart_cursor_i) begin
                cursor_d = '0;
              end
              state_d = S_FETCH;
            end
            default: begin
              state_d = S_DONE;  // unused code: no state change
            end
          endcase
        end
      end
      S_FETCH: begin
        state_d = (cursor_q < count_q) ? S_SKIP : S_DONE;
      end
      S_SKIP: begin
        if (alu_res.carry) begin
          cursor_d = cursor_q + CNT_W'(1);
          state_d  = S_FETCH;
        end else begin
          state_d = S_STOP;
        end
      end
      S_STOP: begin
        state_d = alu_res.carry ? S_DONE : S_LO;
      end
      S_LO: begin
        lo_d    = alu_res.carry ? es : qs_q;
        state_d = S_HI;
      end
      S_HI: begin
        hi_d    = alu_res.carry ? qe_q : ee;
        adv_d   = !alu_res.carry;
        state_d = S_PART;
      end
      S_PART: begin
        part_d  = alu_res.carry ? alu_res.sum : '0;
        state_d = S_ADD;
      end
      S_ADD: begin
        if (alu_res.carry) begin
          stat_d = STAT_OVERFLOW;
        end else begin
          total_d = alu_res.sum;
        end
        if (adv_q) begin
          cursor_d = cursor_q + CNT_W'(1);
          state_d  = S_FETCH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    qs_q    <= qs_d;
    qe_q    <= qe_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    part_q  <= part_d;
    total_q <= total_d;
    stat_q  <= stat_d;
    adv_q   <= adv_d;
    if (out_load) begin
      out_total_q <= total_q;
      out_stat_q  <= stat_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign overlap_total_o = out_total_q;
  assign status_o        = out_stat_q;

  // an accepted item always starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after an accepted item");

  // the walk never passes the end of the table
  a_cursor_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("walk cursor beyond entry count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_INTERVALS))
    else $error("entry count beyond table size");

  // reads only touch written entries
  a_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (cursor_q < count_q))
    else $error("table read beyond entry count");

  // a result is loaded only from the done state and frees the input side
  a_load_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && !in_stall_o))
    else $error("result load did not return to idle");

endmodule
`default_nettype wire

// ===== src/iovl_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module iovl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/iovl_alu.sv =====
// shared 64-bit add / subtract unit with carry out
`default_nettype none
module iovl_alu import iovl_pkg::*; (
  input  wire alu_req_t req_i,
  output alu_res_t      res_o
);

  logic [DATA_W:0]   full;
  logic [DATA_W-1:0] b_op;

  // subtract: carry set means a >= b
  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign full = {1'b0, req_i.a} + {1'b0, b_op} + {{DATA_W{1'b0}}, req_i.sub};

  assign res_o.sum   = full[DATA_W-1:0];
  assign res_o.carry = full[DATA_W];

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the interval overlap accumulator
`timescale 1ns / 1ps
module testbench;
  import iovl_pkg::*;

  // func code that the block must answer without touching its state
  localparam logic [1:0]        FUNC_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0] SPAN_MAX    = '1;

  typedef struct packed {
    logic [DATA_W-1:0] total;
    status_e           status;
  } overlap_result_t;

  // shadow of the interval table and cursor, plus the results still owed
  class overlap_scoreboard;
    logic [DATA_W-1:0] starts [MAX_INTERVALS];
    logic [DATA_W-1:0] ends [MAX_INTERVALS];
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  cursor;
    int unsigned       errors;
    overlap_result_t   owed_q[$];

    function new();
      count  = '0;
      cursor = '0;
      errors = 0;
    endfunction

    // replay one accepted item on the shadow state and queue its result
    function void note_item(input logic [1:0] func, input logic [DATA_W-1:0] qs,
                            input logic [DATA_W-1:0] qe, input logic restart);
      overlap_result_t   res;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] part;
      logic [DATA_W:0]   acc;
      logic [ADDR_W-1:0] idx;
      res.total  = '0;
      res.status = STAT_OK;
      case (func)
        FUNC_CLEAR: begin
          count  = '0;
          cursor = '0;
        end
        FUNC_APPEND: begin
          if (count >= CNT_W'(MAX_INTERVALS)) begin
            res.status = STAT_FULL;
          end else begin
            starts[count[ADDR_W-1:0]] = qs;
            ends[count[ADDR_W-1:0]]   = qe;
            count++;
          end
        end
        FUNC_QUERY: begin
          if (restart) cursor = '0;
          while (cursor < count) begin
            idx = cursor[ADDR_W-1:0];
            // entry wholly before the span: step past it
            if (qs >= ends[idx]) begin
              cursor++;
              continue;
            end
            // entry starts at or after the span end: walk is over
            if (qe <= starts[idx]) break;
            lo   = (starts[idx] > qs) ? starts[idx] : qs;
            hi   = (ends[idx] < qe) ? ends[idx] : qe;
            part = (hi >= lo) ? hi - lo : '0;
            acc  = {1'b0, res.total} + {1'b0, part};
            // a carry out means the overlap is dropped and flagged
            if (acc[DATA_W]) res.status = STAT_OVERFLOW;
            else res.total = acc[DATA_W-1:0];
            if (qe > ends[idx]) cursor++;
            else break;
          end
        end
        default: ;
      endcase
      owed_q = {owed_q, res};
    endfunction

    function void check_result(input logic [DATA_W-1:0] total, input logic [1:0] status);
      overlap_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with no item pending: overlap_total %h status %0d", total, status);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (total !== want.total) begin
        $error("overlap_total mismatch: expected %h actual %h", want.total, total);
        errors++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d actual %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [1:0]        func_i           = FUNC_CLEAR;
  logic [DATA_W-1:0] span_start_i     = '0;
  logic [DATA_W-1:0] span_end_i       = '0;
  logic              restart_cursor_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [DATA_W-1:0] overlap_total_o;
  logic [1:0]        status_o;

  overlap_scoreboard book;
  int unsigned       items_sent    = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;

  interval_overlap_accumulator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .span_start_i     (span_start_i),
    .span_end_i       (span_end_i),
    .restart_cursor_i (restart_cursor_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .overlap_total_o  (overlap_total_o),
    .status_o         (status_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: random stall decided at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // result side: check every result taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_result(overlap_total_o, status_o);
  end

  function automatic logic [DATA_W-1:0] rand64();
    rand64 = {$urandom, $urandom};
  endfunction

  // present one item from a falling edge and hold it until it is taken;
  // returns at the next falling edge
  task automatic send_item(input logic [1:0] func, input logic [DATA_W-1:0] qs,
                           input logic [DATA_W-1:0] qe, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    func_i           = func;
    span_start_i     = qs;
    span_end_i       = qe;
    restart_cursor_i = restart;
    do @(posedge clk_i); while (in_stall_o);
    book.note_item(func, qs, qe, restart);
    if (func != FUNC_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  // append the next interval of an ascending run; wide runs use huge lengths
  // so that overlap sums can carry out
  task automatic append_next(input bit wide, inout logic [DATA_W-1:0] s);
    logic [DATA_W-1:0] len;
    logic [DATA_W-1:0] e;
    s   = s + (wide ? rand64() >> $urandom_range(3, 10) : DATA_W'($urandom_range(0, 40)));
    len = wide ? rand64() >> $urandom_range(0, 3) : DATA_W'($urandom_range(0, 60));
    // now and then an inverted interval
    e   = ($urandom_range(99) < 6) ? s - len : s + len;
    send_item(FUNC_APPEND, s, e, 1'($urandom_range(1)));
  endtask

  // one random sequence: mostly clear, ascending appends, then queries that
  // walk forward through the table with the odd late append and restart
  task automatic run_sequence();
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] qs;
    logic [DATA_W-1:0] qe;
    logic [DATA_W-1:0] delta;
    logic              restart;
    bit                wide;
    int unsigned       kind;
    int unsigned       pick;
    kind = $urandom_range(99);
    // noise: any func, any payload
    if (kind < 12) begin
      repeat ($urandom_range(1, 6))
        send_item(2'($urandom_range(3)), rand64(), rand64(), 1'($urandom_range(1)));
      return;
    end
    wide = ($urandom_range(99) < 25);
    // a few sequences build on whatever table is left over
    if (kind < 95) send_item(FUNC_CLEAR, rand64(), rand64(), 1'($urandom_range(1)));
    s  = wide ? rand64() >> 2 : rand64() >> 1;
    lo = s;
    p  = s;
    repeat ($urandom_range(1, 10)) append_next(wide, s);
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(99) < 15) begin
        append_next(wide, s);
      end else begin
        restart = ($urandom_range(99) < 25);
        pick    = $urandom_range(99);
        if (restart) p = lo;
        if (pick < 10) begin
          // span covering the whole run
          qs      = lo - DATA_W'($urandom_range(0, 20));
          qe      = SPAN_MAX;
          restart = 1'b1;
        end else if (pick < 15) begin
          qs = rand64();
          qe = rand64();
        end else begin
          // walk forward from the last span, sometimes stepping back a bit
          delta = wide ? rand64() >> $urandom_range(3, 10) : DATA_W'($urandom_range(0, 30));
          qs    = ($urandom_range(3) == 0) ? p - delta : p + delta;
          qe    = qs + (wide ? rand64() >> $urandom_range(1, 6) : DATA_W'($urandom_range(0, 80)));
          p     = qe - (wide ? '0 : DATA_W'($urandom_range(0, 10)));
        end
        send_item(FUNC_QUERY, qs, qe, restart);
      end
    end
  endtask

  // fill the table to the brim, push past it, then walk the full table
  task automatic run_full_table();
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] qs;
    logic [DATA_W-1:0] qe;
    send_item(FUNC_CLEAR, '0, '0, 1'b0);
    s  = rand64() >> 2;
    lo = s;
    // the last three appends find the table full
    repeat (MAX_INTERVALS + 3) begin
      s = s + DATA_W'($urandom_range(0, 8));
      send_item(FUNC_APPEND, s, s + DATA_W'($urandom_range(0, 20)), 1'($urandom_range(1)));
    end
    p = lo;
    repeat (8) begin
      qs = p + DATA_W'($urandom_range(0, 200));
      qe = qs + DATA_W'($urandom_range(0, 3000));
      send_item(FUNC_QUERY, qs, qe, 1'b0);
      p = qe;
    end
    send_item(FUNC_QUERY, lo, SPAN_MAX, 1'b1);
    send_item(FUNC_QUERY, rand64(), rand64(), 1'b1);
    send_item(FUNC_QUERY, lo, lo + DATA_W'($urandom_range(0, 500)), 1'b1);
  endtask

  initial begin
    book = new();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, no idling on either side
    send_item(FUNC_QUERY, 64'd0, 64'd100, 1'b0);          // empty table
    send_item(FUNC_UNUSED, SPAN_MAX, SPAN_MAX, 1'b1);     // unused code
    send_item(FUNC_APPEND, 64'd10, 64'd20, 1'b0);
    send_item(FUNC_APPEND, 64'd30, 64'd50, 1'b1);
    send_item(FUNC_APPEND, 64'd40, 64'd35, 1'b0);         // inverted interval
    send_item(FUNC_APPEND, 64'd60, 64'd60, 1'b0);         // empty interval
    send_item(FUNC_QUERY, 64'd0, 64'd100, 1'b1);
    send_item(FUNC_QUERY, 64'd15, 64'd45, 1'b1);          // stops inside an entry
    send_item(FUNC_QUERY, 64'd45, 64'd55, 1'b0);          // resumes at the cursor
    send_item(FUNC_QUERY, 64'd0, 64'd5, 1'b1);            // ends before the first entry
    send_item(FUNC_QUERY, 64'd0, SPAN_MAX, 1'b1);
    send_item(FUNC_CLEAR, SPAN_MAX, SPAN_MAX, 1'b1);
    send_item(FUNC_APPEND, 64'd0, SPAN_MAX - 64'd1, 1'b0);
    send_item(FUNC_APPEND, 64'd1, SPAN_MAX - 64'd1, 1'b0);
    send_item(FUNC_APPEND, SPAN_MAX - 64'd15, SPAN_MAX, 1'b0);
    send_item(FUNC_QUERY, 64'd0, SPAN_MAX, 1'b1);         // sum carries out
    send_item(FUNC_QUERY, SPAN_MAX, SPAN_MAX, 1'b1);      // skips every entry
    send_item(FUNC_QUERY, 64'd0, SPAN_MAX, 1'b0);         // cursor at the end
    send_item(FUNC_APPEND, 64'd5, 64'd7, 1'b0);           // out of order append
    send_item(FUNC_QUERY, 64'd0, 64'd10, 1'b1);
    send_item(FUNC_CLEAR, 64'd0, 64'd0, 1'b0);
    send_item(FUNC_QUERY, 64'd0, SPAN_MAX, 1'b1);         // right after a clear

    // random part: receiver lazy first, then sender lazy, then flat out
    send_idle_pct = 30;
    recv_idle_pct = 58;
    while (items_sent < 350) run_sequence();
    send_idle_pct = 58;
    recv_idle_pct = 30;
    while (items_sent < 700) run_sequence();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 800) run_sequence();
    run_full_table();
    in_valid_i = 1'b0;

    // drain, then give stray results a chance to show up
    while (book.owed_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (book.errors == 0 && book.owed_q.size() == 0) begin
      $display("interval_overlap_accumulator test passed");
    end else begin
      $display("interval_overlap_accumulator test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("interval_overlap_accumulator test failed");
    $finish;
  end

endmodule
